[sv/osc_float_message_parser_unit_macros.svh]
// Assertion macros for the OSC float message parser.
`ifndef OSC_FLOAT_MESSAGE_PARSER_UNIT_MACROS_SVH
`define OSC_FLOAT_MESSAGE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define OFMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define OFMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ofmp_pkg.sv]
// Package: types, constants and helpers of the OSC float message parser.
package ofmp_pkg;

    localparam int unsigned MAX_DATAGRAM_BYTES = 255;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [8:0] PATH_CAPACITY_RESET = 9'd64;

    typedef enum logic [2:0] {
        PH_ADDR     = 3'd0,
        PH_TAG_WAIT = 3'd1,
        PH_TAG      = 3'd2,
        PH_VAL_WAIT = 3'd3,
        PH_VAL      = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_DATA     = 2'd1,
        STATUS_MALFORMED   = 2'd2,
        STATUS_UNSUPPORTED = 2'd3
    } status_t;

    // Round up to a multiple of 4.
    function automatic logic [9:0] pad4(input logic [9:0] n);
        pad4 = (n + 10'd3) & ~10'd3;
    endfunction

endpackage

[sv/osc_float_message_parser_unit.sv]
// Top level: OSC float message parser, one datagram byte per item.
//
// Input stream s_axis: one datagram byte per item in tdata, tlast on the final
// byte, tuser high for an empty receive (byte ignored).
// Output stream m_axis: tuser low for an address character item (tdata holds
// the byte), tuser high for the end-of-message status item (length, float bits,
// status). Address bytes are emitted up to path_capacity-1 of them; on a bad
// status the consumer drops the characters already taken.
// cfg_wr_en/cfg_wr_data write path_capacity; the user must do so while the block is
// idle, which the block does not enforce. Throughput: one item per cycle while the
// output is not stalled. A result is registered; it appears in the cycle after its
// item is accepted, once the byte counter, parse phase and float shift register update.
// Reset: parse state clears, path_capacity returns to 64, no item pending.
// Stall: the result register holds its item while m_axis_tready is low, and
// s_axis_tready is low only while a result is held and not taken.
`include "osc_float_message_parser_unit_macros.svh"

module osc_float_message_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,     // path_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte
    input  logic        s_axis_tlast,    // last_byte
    input  logic        s_axis_tuser,    // empty_datagram
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,    // path_char[7:0], path_length[15:8],
                                         // value_bits[47:16], status[49:48], zero pad
    output logic        m_axis_tuser     // is_final
);

    logic [8:0]          path_capacity_reg;
    logic [7:0]          byte_position_reg, byte_position_next;
    ofmp_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]          path_count_reg, path_count_next;
    logic [8:0]          tag_start_reg, tag_start_next;
    logic [8:0]          value_start_reg, value_start_next;
    logic [31:0]         value_shift_reg, value_shift_next;
    logic                malformed_reg, malformed_next;
    logic                unsupported_reg, unsupported_next;

    logic                out_valid_reg;
    logic                out_final_reg, out_final_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic [7:0]          out_len_reg, out_len_next;
    logic [31:0]         out_value_reg, out_value_next;
    ofmp_pkg::status_t   out_status_reg, out_status_next;
    logic                has_result;

    logic                in_accept;
    logic                emit;
    logic [8:0]          limit;
    ofmp_pkg::status_t   status;
    logic [9:0]          tag_diff;
    logic [9:0]          vs_sum;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign limit         = path_capacity_reg - 9'd1;

    always_comb
    begin
        byte_position_next = byte_position_reg;
        phase_next         = phase_reg;
        path_count_next    = path_count_reg;
        tag_start_next     = tag_start_reg;
        value_start_next   = value_start_reg;
        value_shift_next   = value_shift_reg;
        malformed_next     = malformed_reg;
        unsupported_next   = unsupported_reg;
        emit               = 1'b0;
        status             = ofmp_pkg::STATUS_OK;
        has_result         = 1'b0;
        out_final_next     = 1'b0;
        out_char_next      = 8'd0;
        out_len_next       = 8'd0;
        out_value_next     = 32'd0;
        out_status_next    = ofmp_pkg::STATUS_OK;
        tag_diff           = 10'd0;
        vs_sum             = 10'd0;

        if (s_axis_tuser)
        begin
            has_result      = 1'b1;
            out_final_next  = 1'b1;
            out_status_next = ofmp_pkg::STATUS_NO_DATA;
        end
        else
        begin
            if (32'(byte_position_reg) < ofmp_pkg::MAX_DATAGRAM_BYTES)
            begin
                byte_position_next = byte_position_reg + 8'd1;
                if (!malformed_reg)
                begin
                    if (phase_reg == ofmp_pkg::PH_ADDR)
                    begin
                        if (byte_position_reg == 8'd0 && s_axis_tdata != ofmp_pkg::CHAR_SLASH)
                        begin
                            malformed_next = 1'b1;
                            phase_next     = ofmp_pkg::PH_DONE;
                        end
                        else if (s_axis_tdata == ofmp_pkg::CHAR_NUL)
                        begin
                            tag_start_next = 9'(ofmp_pkg::pad4({2'b00, byte_position_reg} + 10'd1));
                            phase_next     = ofmp_pkg::PH_TAG_WAIT;
                        end
                        else
                        begin
                            emit = ({1'b0, path_count_reg} < limit);
                        end
                    end
                    else
                    begin
                        if (phase_reg == ofmp_pkg::PH_TAG_WAIT
                            && {1'b0, byte_position_reg} == tag_start_reg)
                        begin
                            phase_next = ofmp_pkg::PH_TAG;
                        end
                        if (phase_next == ofmp_pkg::PH_TAG)
                        begin
                            if ({1'b0, byte_position_reg} == tag_start_reg
                                && s_axis_tdata != ofmp_pkg::CHAR_COMMA)
                            begin
                                malformed_next = 1'b1;
                                phase_next     = ofmp_pkg::PH_DONE;
                            end
                            else
                            begin
                                if ({2'b00, byte_position_reg} == {1'b0, tag_start_reg} + 10'd1
                                    && s_axis_tdata != ofmp_pkg::CHAR_F)
                                begin
                                    unsupported_next = 1'b1;
                                end
                                if (s_axis_tdata == ofmp_pkg::CHAR_NUL)
                                begin
                                    tag_diff = {2'b00, byte_position_reg}
                                               - {1'b0, tag_start_reg} + 10'd1;
                                    vs_sum   = {1'b0, tag_start_reg} + ofmp_pkg::pad4(tag_diff);
                                    value_start_next = vs_sum[8:0];
                                    phase_next       = ofmp_pkg::PH_VAL_WAIT;
                                end
                            end
                        end
                        else
                        begin
                            if (phase_reg == ofmp_pkg::PH_VAL_WAIT
                                && {1'b0, byte_position_reg} == value_start_reg)
                            begin
                                phase_next = ofmp_pkg::PH_VAL;
                            end
                            if (phase_next == ofmp_pkg::PH_VAL)
                            begin
                                value_shift_next = {value_shift_reg[23:0], s_axis_tdata};
                                if ({2'b00, byte_position_reg}
                                    == {1'b0, value_start_reg} + 10'd3)
                                begin
                                    phase_next = ofmp_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                end
            end

            if (malformed_next || phase_next == ofmp_pkg::PH_ADDR)
                status = ofmp_pkg::STATUS_MALFORMED;
            else if ({2'b00, byte_position_next} < {1'b0, tag_start_next} + 10'd4)
                status = ofmp_pkg::STATUS_MALFORMED;
            else if (unsupported_next)
                status = ofmp_pkg::STATUS_UNSUPPORTED;
            else if (phase_next == ofmp_pkg::PH_DONE)
                status = ofmp_pkg::STATUS_OK;
            else
                status = ofmp_pkg::STATUS_MALFORMED;

            if (s_axis_tlast)
            begin
                has_result      = 1'b1;
                out_final_next  = 1'b1;
                out_len_next    = path_count_reg;
                out_value_next  = (status == ofmp_pkg::STATUS_OK) ? value_shift_next : 32'd0;
                out_status_next = status;
            end
            else if (emit)
            begin
                has_result      = 1'b1;
                out_char_next   = s_axis_tdata;
                path_count_next = path_count_reg + 8'd1;
            end
        end

        // Any status item returns the parse state to its reset value.
        if (s_axis_tuser || s_axis_tlast)
        begin
            byte_position_next = 8'd0;
            phase_next         = ofmp_pkg::PH_ADDR;
            path_count_next    = 8'd0;
            tag_start_next     = 9'd0;
            value_start_next   = 9'd0;
            value_shift_next   = 32'd0;
            malformed_next     = 1'b0;
            unsupported_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_capacity_reg <= ofmp_pkg::PATH_CAPACITY_RESET;
            byte_position_reg <= 8'd0;
            phase_reg         <= ofmp_pkg::PH_ADDR;
            path_count_reg    <= 8'd0;
            tag_start_reg     <= 9'd0;
            value_start_reg   <= 9'd0;
            value_shift_reg   <= 32'd0;
            malformed_reg     <= 1'b0;
            unsupported_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                path_capacity_reg <= cfg_wr_data;
            if (in_accept)
            begin
                byte_position_reg <= byte_position_next;
                phase_reg         <= phase_next;
                path_count_reg    <= path_count_next;
                tag_start_reg     <= tag_start_next;
                value_start_reg   <= value_start_next;
                value_shift_reg   <= value_shift_next;
                malformed_reg     <= malformed_next;
                unsupported_reg   <= unsupported_next;
                out_valid_reg     <= has_result;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && has_result)
        begin
            out_final_reg  <= out_final_next;
            out_char_reg   <= out_char_next;
            out_len_reg    <= out_len_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_final_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_value_reg, out_len_reg, out_char_reg};

    `OFMP_ASSERT_NOW(a_char_item_clean,
        m_axis_tvalid && !m_axis_tuser,
        out_status_reg == ofmp_pkg::STATUS_OK && out_value_reg == 32'd0 && out_len_reg == 8'd0,
        "character item carries nonzero status fields")
    `OFMP_ASSERT_NOW(a_bad_status_no_value,
        m_axis_tvalid && m_axis_tuser && out_status_reg != ofmp_pkg::STATUS_OK,
        out_value_reg == 32'd0,
        "float bits present on a failed message")
    `OFMP_ASSERT_NEXT(a_empty_gives_no_data,
        in_accept && s_axis_tuser,
        m_axis_tvalid && m_axis_tuser && out_status_reg == ofmp_pkg::STATUS_NO_DATA,
        "empty receive did not produce a no-data status")
    `OFMP_ASSERT_NEXT(a_end_clears_parse,
        in_accept && (s_axis_tuser || s_axis_tlast),
        byte_position_reg == 8'd0 && path_count_reg == 8'd0 && phase_reg == ofmp_pkg::PH_ADDR,
        "parse state not cleared after a status item")

endmodule
